/* rtl/utf8_byte_stream_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define UTF8D_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, result kinds, queue operation codes and the queue word type.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W        = 21;
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 2;
	localparam int OP_W        = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = CP_W'(21'h00FFFD);
	localparam logic [CP_W-1:0] CP_ZERO        = '0;

	// Result kinds as seen on the output tuser.
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// Work handed from the front to the back.
	localparam logic [OP_W-1:0] OP_CHAR    = 2'd0;
	localparam logic [OP_W-1:0] OP_BAD     = 2'd1;
	localparam logic [OP_W-1:0] OP_END     = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD_END = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [CP_W-1:0] cp;
	} utf8d_op_t;

endpackage

/* rtl/utf8d_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the partial sequence and posts result work.
// ----------------------------------------------------------------------------
module utf8d_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_byte,
	output logic                      push,
	output utf8d_pkg::utf8d_op_t      push_data,
	input  logic                      queue_full
);
	import utf8d_pkg::*;

	logic [CP_W-1:0] partial_q;
	logic [1:0]      pending_q;
	logic [CP_W-1:0] partial_d;
	logic [1:0]      pending_d;
	logic [CP_W-1:0] shifted;
	logic            accept;
	logic            emit;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && emit;
	assign shifted  = {partial_q[CP_W-7:0], in_byte[5:0]};

	always_comb begin
		partial_d      = partial_q;
		pending_d      = pending_q;
		emit           = 1'b0;
		push_data.op   = OP_CHAR;
		push_data.cp   = CP_ZERO;
		if (in_byte == 8'h00) begin
			// A terminator cuts off any open sequence.
			emit         = 1'b1;
			push_data.op = (pending_q != 2'd0) ? OP_BAD_END : OP_END;
			partial_d    = CP_ZERO;
			pending_d    = 2'd0;
		end else if (pending_q != 2'd0) begin
			// Continuation bytes are taken without checking their top bits.
			pending_d = pending_q - 2'd1;
			if (pending_q == 2'd1) begin
				emit         = 1'b1;
				push_data.cp = shifted;
				partial_d    = CP_ZERO;
			end else begin
				partial_d = shifted;
			end
		end else if (in_byte[7] == 1'b0) begin
			emit         = 1'b1;
			push_data.cp = CP_W'(in_byte);
		end else if (in_byte[7:5] == 3'b110) begin
			partial_d = CP_W'(in_byte[4:0]);
			pending_d = 2'd1;
		end else if (in_byte[7:4] == 4'b1110) begin
			partial_d = CP_W'(in_byte[3:0]);
			pending_d = 2'd2;
		end else if (in_byte[7:3] == 5'b11110) begin
			partial_d = CP_W'(in_byte[2:0]);
			pending_d = 2'd3;
		end else begin
			emit         = 1'b1;
			push_data.op = OP_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_d;
			pending_q <= pending_d;
		end
	end

endmodule

/* rtl/utf8d_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder work queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_core_defines.svh"

module utf8d_queue #(
	parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  utf8d_pkg::utf8d_op_t push_data,
	input  logic                 pop,
	output utf8d_pkg::utf8d_op_t head,
	output logic                 full,
	output logic                 empty
);
	import utf8d_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8d_op_t        store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the last entry, so any depth works.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`UTF8D_ASSERT_IMPLY(a_no_push_full, push, !full || pop, "queue written while full")
	`UTF8D_ASSERT_IMPLY(a_no_pop_empty, pop, !empty, "queue read while empty")
	`UTF8D_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overrun")

endmodule

/* rtl/utf8d_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Turns queued work into result words held in the output register.
// ----------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_core_defines.svh"

module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::utf8d_op_t head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [20:0]          out_cp,
	output logic [1:0]           out_kind,
	output logic                 out_last
);
	import utf8d_pkg::*;

	logic              out_valid_q;
	logic [CP_W-1:0]   out_cp_q;
	logic [KIND_W-1:0] out_kind_q;
	logic              out_last_q;
	logic              phase_q;
	logic              load;

	// The end marker after a cut-off sequence is issued from phase_q,
	// so that work word leaves the queue on its first result.
	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !phase_q && !empty;
	assign out_valid = out_valid_q;
	assign out_cp    = out_cp_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			if (phase_q) begin
				out_valid_q <= 1'b1;
				phase_q     <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				phase_q     <= !empty && (head.op == OP_BAD_END);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				out_cp_q   <= CP_ZERO;
				out_kind_q <= KIND_END;
				out_last_q <= 1'b1;
			end else begin
				case (head.op)
					OP_CHAR: begin
						out_cp_q   <= head.cp;
						out_kind_q <= KIND_CHAR;
						out_last_q <= 1'b1;
					end
					OP_BAD: begin
						out_cp_q   <= CP_REPLACEMENT;
						out_kind_q <= KIND_BAD;
						out_last_q <= 1'b1;
					end
					OP_END: begin
						out_cp_q   <= CP_ZERO;
						out_kind_q <= KIND_END;
						out_last_q <= 1'b1;
					end
					OP_BAD_END: begin
						out_cp_q   <= CP_REPLACEMENT;
						out_kind_q <= KIND_BAD;
						out_last_q <= 1'b0;
					end
					default: begin
						out_cp_q   <= CP_ZERO;
						out_kind_q <= KIND_END;
						out_last_q <= 1'b1;
					end
				endcase
			end
		end
	end

	`UTF8D_ASSERT_IMPLY(a_phase_holds_bad, phase_q,
		out_valid_q && out_kind_q == KIND_BAD && !out_last_q,
		"second phase without a pending replacement word")
	`UTF8D_ASSERT_IMPLY(a_nonlast_is_bad, out_valid_q && !out_last_q,
		phase_q, "non-final word outside a cut-off sequence")
	`UTF8D_ASSERT_NEXT(a_end_follows, phase_q && out_ready,
		out_valid_q && out_kind_q == KIND_END && out_last_q,
		"end marker did not follow the replacement")

endmodule

/* rtl/utf8_byte_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Decodes one UTF-8 byte per cycle into code points with result kinds.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the s_ group, one per word. Each decoded character, each
// replacement (U+FFFD, kind 1) and each end-of-string marker (kind 2) leaves
// on the m_ group as one word; m_tlast marks the final word caused by a byte.
// A zero byte ends the string; inside an open sequence it gives a replacement
// word followed by the end marker.
// Throughput is one byte per cycle. A byte that completes a result is written
// to the work queue, then to the output register that drives m_tvalid. A zero
// byte that cuts off a sequence gives two output words, which the queue absorbs.
// The front end only stalls (s_tready low) when the work queue of
// QUEUE_DEPTH words is full, which happens while the receiver holds m_tready
// low. A stalled output word stays stable until taken.
// Reset clears the sequence state, empties the queue and drops any pending
// output word.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core #(
	parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);
	import utf8d_pkg::*;

	utf8d_op_t   push_data;
	utf8d_op_t   head;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	logic [20:0] code_point;

	utf8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.push       (push),
		.push_data  (push_data),
		.queue_full (full)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	utf8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cp    (code_point),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, code_point};

endmodule

/* sim/utf8_byte_stream_decoder_core_tb.sv */
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder testbench
// Streams directed and random UTF-8 bytes into the decoder and compares every
// output word with a behavioral decoder kept in the testbench, under several
// patterns of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import utf8d_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic [KIND_W-1:0] kind;
		logic              last;
	} cp_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Decoder state as predicted by the testbench.
	logic [CP_W-1:0] acc_cp = '0;
	logic [1:0]      cont_left = '0;

	cp_word_t decoded_q[$];
	int       errors = 0;
	int       bytes_sent = 0;
	int       src_idle_pct = 0;
	int       snk_stall_pct = 0;
	logic     hold_toggle = 1'b0;
	logic     hold_seen = 1'b0;
	int       hold_left = 0;
	int       idle_cycles = 0;

	utf8_byte_stream_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic void push_word(logic [CP_W-1:0] cp, logic [KIND_W-1:0] kind,
			logic last);
		cp_word_t w;
		w.cp   = cp;
		w.kind = kind;
		w.last = last;
		decoded_q.push_back(w);
	endfunction

	// Advances the predicted decoder by one byte and queues the words it causes.
	function automatic void decode_byte(logic [7:0] b);
		if (b == 8'h00) begin
			if (cont_left != 2'd0) begin
				push_word(CP_REPLACEMENT, KIND_BAD, 1'b0);
				acc_cp    = '0;
				cont_left = 2'd0;
			end
			push_word(CP_ZERO, KIND_END, 1'b1);
		end else if (cont_left != 2'd0) begin
			// Any nonzero byte counts as a continuation here, whatever its top bits.
			acc_cp    = {acc_cp[CP_W-7:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				push_word(acc_cp, KIND_CHAR, 1'b1);
				acc_cp = '0;
			end
		end else if (b[7] == 1'b0) begin
			push_word(CP_W'(b), KIND_CHAR, 1'b1);
		end else if (b[7:5] == 3'b110) begin
			acc_cp    = CP_W'(b[4:0]);
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			acc_cp    = CP_W'(b[3:0]);
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			acc_cp    = CP_W'(b[2:0]);
			cont_left = 2'd3;
		end else begin
			push_word(CP_REPLACEMENT, KIND_BAD, 1'b1);
		end
	endfunction

	// Sink side: checks each accepted word and drives tready with random stalls.
	always @(posedge clk) begin
		cp_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected word: code point %h, kind %0d, last %0b",
						$time, m_tdata[CP_W-1:0], m_tuser, m_tlast);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata[CP_W-1:0] !== want.cp) begin
						$display("%0t: code point mismatch: expected %h, actual %h",
							$time, want.cp, m_tdata[CP_W-1:0]);
						errors++;
					end
					if (m_tuser !== want.kind) begin
						$display("%0t: kind mismatch: expected %0d, actual %0d",
							$time, want.kind, m_tuser);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, m_tlast);
						errors++;
					end
				end
			end
			if (hold_toggle != hold_seen) begin
				hold_seen <= hold_toggle;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			if (hold_left > 0)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	// Lets the output run dry, then gives the block time for any late word.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed sequences with random payload, plus noise and cut-off
	// sequences.
	task automatic send_random_chunk;
		int r;
		int n_cont;
		int n_sent;
		logic [7:0] lead;
		r = $urandom_range(99);
		n_cont = $urandom_range(3, 1);
		case (n_cont)
			1: lead = 8'hC0 | 8'($urandom_range(31));
			2: lead = 8'hE0 | 8'($urandom_range(15));
			default: lead = 8'hF0 | 8'($urandom_range(7));
		endcase
		if (r < 30) begin
			send_byte(8'($urandom_range(8'h7F, 1)));
		end else if (r < 70) begin
			send_byte(lead);
			repeat (n_cont) send_byte(8'h80 | 8'($urandom_range(63)));
		end else if (r < 78) begin
			send_byte(8'h00);
		end else if (r < 90) begin
			send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(lead);
			n_sent = $urandom_range(n_cont - 1);
			repeat (n_sent) send_byte(8'h80 | 8'($urandom_range(63)));
			// Either a zero cutting the sequence or an odd byte taken as continuation.
			if ($urandom_range(1))
				send_byte(8'h00);
			else
				send_byte(8'($urandom_range(255, 1)));
		end
	endtask

	task automatic test_directed;
		logic [7:0] seq[] = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF, 8'hF8,
			8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hC0, 8'h80, 8'hE1, 8'h41, 8'hFF, 8'hF0, 8'h00, 8'h00};
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		foreach (seq[i]) send_byte(seq[i]);
		drain();
	endtask

	task automatic test_random(input int n_bytes, input int src_pct, input int snk_pct);
		int target;
		target = bytes_sent + n_bytes;
		src_idle_pct = src_pct;
		snk_stall_pct <= snk_pct;
		while (bytes_sent < target) send_random_chunk();
		drain();
	endtask

	// The sink holds off long enough for the internal queue to fill and stall
	// the input while the source keeps offering bytes.
	task automatic test_backpressure;
		int target;
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		hold_toggle <= ~hold_toggle;
		target = bytes_sent + 80;
		while (bytes_sent < target) send_random_chunk();
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 59, 0);
		test_random(300, 0, 59);
		test_random(300, 15, 15);
		test_backpressure();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
